// ===== rtl/core/drp_pkg.sv =====
// ----------------------------------------------------------------------------
// drp_pkg
// Shared types and constants for the dead reckoning position block.
// ----------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

	localparam int POINT_INTERVAL_DEF = 20;
	localparam int CORDIC_STEPS_DEF   = 16;

	localparam int POS_W   = 24;
	localparam int HEAD_W  = 16;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W   = 5;

	// cordic vector and angle widths
	localparam int COR_XW = 34;
	localparam int COR_ZW = 20;
	localparam int CORDIC_GAIN_Q30 = 652032874;
	localparam int PI_Q16      = 205887;
	localparam int HALF_PI_Q16 = 102944;

	localparam logic [CFG_W-1:0] SCALE_RST   = 24'd65536;
	localparam logic [CFG_W-1:0] X_OFFSET_RST = 24'd6912;
	localparam logic [CFG_W-1:0] Y_OFFSET_RST = 24'd133504;
	localparam logic [CFG_W-1:0] START_X_RST = 24'd7680;
	localparam logic [CFG_W-1:0] START_Y_RST = 24'd18330;

	typedef enum logic [1:0] {
		OP_YAW = 2'd0,
		OP_ENC = 2'd1,
		OP_GPS = 2'd2
	} op_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE    = 3'd0,
		REG_X_OFFSET = 3'd1,
		REG_Y_OFFSET = 3'd2,
		REG_START_X  = 3'd3,
		REG_START_Y  = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_D_LO,
		ST_D_HI,
		ST_D_ACC,
		ST_D_RND,
		ST_COR_WAIT,
		ST_X_LO,
		ST_X_HI,
		ST_X_ACC,
		ST_X_FIN,
		ST_Y_LO,
		ST_Y_HI,
		ST_Y_ACC,
		ST_Y_FIN,
		ST_G_X,
		ST_G_N,
		ST_G_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_e_t                     opcode;
		logic signed [HEAD_W-1:0]  heading_rad;
		logic signed [POS_W-1:0]   rotations;
		logic signed [POS_W-1:0]   gps_east;
		logic signed [POS_W-1:0]   gps_north;
	} drp_req_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic                    point_marker;
	} drp_res_t;

	typedef struct packed {
		logic                     done;
		logic signed [COR_XW-1:0] cos_v;
		logic signed [COR_XW-1:0] sin_v;
	} cor_res_t;

	// arctangent of 2^-i in Q.16 radians
	function automatic logic [16:0] atan_q16(input logic [4:0] idx);
		logic [16:0] a;
		case (idx)
			5'd0:    a = 17'd51472;
			5'd1:    a = 17'd30386;
			5'd2:    a = 17'd16055;
			5'd3:    a = 17'd8150;
			5'd4:    a = 17'd4091;
			5'd5:    a = 17'd2047;
			5'd6:    a = 17'd1024;
			5'd7:    a = 17'd512;
			5'd8:    a = 17'd256;
			5'd9:    a = 17'd128;
			5'd10:   a = 17'd64;
			5'd11:   a = 17'd32;
			5'd12:   a = 17'd16;
			5'd13:   a = 17'd8;
			5'd14:   a = 17'd4;
			5'd15:   a = 17'd2;
			5'd16:   a = 17'd1;
			default: a = 17'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dead_reckoning_position.sv =====
// ----------------------------------------------------------------------------
// dead_reckoning_position
// Wheel odometry dead reckoning with heading updates and gps fixes.
// ----------------------------------------------------------------------------
// One request at a time. A yaw update or an unused opcode goes from
// acceptance to the done state and a gps fix through two multiply states
// and a finish state; an encoder reading waits for the cordic unit doing
// one micro-rotation per cycle, followed by the distance times cos and sin
// products on one shared 25x18 multiplier that forms each product in two
// halves. req_stall is high from acceptance until the result enters the
// output register; a finished result may wait there while the next request
// is taken. Configuration writes are always ready and take effect at once;
// a start_x or start_y write also reloads the anchor.
`default_nettype none

module dead_reckoning_position #(
	parameter int POINT_INTERVAL = drp_pkg::POINT_INTERVAL_DEF,
	parameter int CORDIC_STEPS   = drp_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire drp_pkg::drp_req_t                  req_data,
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output drp_pkg::drp_res_t                       res_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [drp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [drp_pkg::CFG_W-1:0]          cfg_data
);
	import drp_pkg::*;

	localparam int ACC_W = 58;
	localparam int MA_W  = 25;
	localparam int MB_W  = 18;
	localparam int MP_W  = MA_W + MB_W;
	localparam logic signed [MB_W-1:0]  GPS_SCALE = 18'sd100;
	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-23){1'b0}}, {23{1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-23){1'b1}}, {23{1'b0}}};

	function automatic logic signed [POS_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI[POS_W-1:0];
		else if (v < SAT_LO)
			r = SAT_LO[POS_W-1:0];
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	state_t state_q, state_d;

	logic [CFG_W-1:0]          scale_q;
	logic signed [POS_W-1:0]   xoff_q, yoff_q;
	logic signed [HEAD_W-1:0]  heading_q;
	logic signed [POS_W-1:0]   cur_x_q, cur_y_q, anchor_x_q, anchor_y_q;
	logic                      first_fix_q;
	logic [CNT_W-1:0]          count_q;
	logic                      marker_q;
	drp_req_t                  item_q;
	logic signed [POS_W-1:0]   dist_q;
	logic signed [MP_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      res_valid_q;
	drp_res_t                  res_q;

	logic                      accept, cor_start, res_load;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	cor_res_t                  cor_res;

	logic signed [ACC_W-1:0]   prod_ext, dist_rnd, pos_rnd, gps_rnd;
	logic signed [POS_W-1:0]   pos_x_new, pos_y_new, gps_x_new, gps_y_new;
	logic [CNT_W-1:0]          count_inc;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign cor_start = accept && (req_data.opcode == OP_ENC);

	drp_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.heading (heading_q),
		.res     (cor_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_data.opcode)
						OP_YAW:  state_d = ST_DONE;
						OP_ENC:  state_d = ST_D_LO;
						OP_GPS:  state_d = ST_G_X;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_D_LO: begin
				mul_a   = {item_q.rotations[POS_W-1], item_q.rotations};
				mul_b   = {6'b0, scale_q[11:0]};
				state_d = ST_D_HI;
			end
			ST_D_HI: begin
				mul_a   = {item_q.rotations[POS_W-1], item_q.rotations};
				mul_b   = {6'b0, scale_q[23:12]};
				state_d = ST_D_ACC;
			end
			ST_D_ACC:    state_d = ST_D_RND;
			ST_D_RND:    state_d = ST_COR_WAIT;
			ST_COR_WAIT: begin
				if (cor_res.done)
					state_d = ST_X_LO;
			end
			ST_X_LO: begin
				mul_a   = {dist_q[POS_W-1], dist_q};
				mul_b   = {1'b0, cor_res.cos_v[16:0]};
				state_d = ST_X_HI;
			end
			ST_X_HI: begin
				mul_a   = {dist_q[POS_W-1], dist_q};
				mul_b   = {cor_res.cos_v[COR_XW-1], cor_res.cos_v[COR_XW-1:17]};
				state_d = ST_X_ACC;
			end
			ST_X_ACC:    state_d = ST_X_FIN;
			ST_X_FIN:    state_d = ST_Y_LO;
			ST_Y_LO: begin
				mul_a   = {dist_q[POS_W-1], dist_q};
				mul_b   = {1'b0, cor_res.sin_v[16:0]};
				state_d = ST_Y_HI;
			end
			ST_Y_HI: begin
				mul_a   = {dist_q[POS_W-1], dist_q};
				mul_b   = {cor_res.sin_v[COR_XW-1], cor_res.sin_v[COR_XW-1:17]};
				state_d = ST_Y_ACC;
			end
			ST_Y_ACC:    state_d = ST_Y_FIN;
			ST_Y_FIN:    state_d = ST_DONE;
			ST_G_X: begin
				mul_a   = {item_q.gps_east[POS_W-1], item_q.gps_east};
				mul_b   = GPS_SCALE;
				state_d = ST_G_N;
			end
			ST_G_N: begin
				mul_a   = {item_q.gps_north[POS_W-1], item_q.gps_north};
				mul_b   = GPS_SCALE;
				state_d = ST_G_FIN;
			end
			ST_G_FIN:    state_d = ST_DONE;
			ST_DONE: begin
				if (!res_valid_q || !res_stall) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// rounding, saturation and the position sums
	always_comb begin
		prod_ext  = ACC_W'(prod_q);
		dist_rnd  = (acc_q + ACC_W'(32768)) >>> 16;
		pos_rnd   = (acc_q + ACC_W'(536870912)) >>> 30;
		gps_rnd   = (prod_ext + ACC_W'(128)) >>> 8;
		pos_x_new = sat24(ACC_W'(anchor_x_q) + pos_rnd);
		pos_y_new = sat24(ACC_W'(anchor_y_q) + pos_rnd);
		gps_x_new = sat24(ACC_W'(xoff_q) + gps_rnd);
		gps_y_new = sat24(ACC_W'(yoff_q) - gps_rnd);
		count_inc = count_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept)
			item_q <= req_data;
		unique case (state_q)
			ST_D_HI, ST_X_HI, ST_Y_HI: acc_q <= prod_ext;
			ST_D_ACC: acc_q <= acc_q + (prod_ext <<< 12);
			ST_X_ACC, ST_Y_ACC: acc_q <= acc_q + (prod_ext <<< 17);
			default: acc_q <= acc_q;
		endcase
		if (state_q == ST_D_RND)
			dist_q <= sat24(dist_rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_RST;
			xoff_q      <= X_OFFSET_RST;
			yoff_q      <= Y_OFFSET_RST;
			anchor_x_q  <= START_X_RST;
			anchor_y_q  <= START_Y_RST;
			heading_q   <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			first_fix_q <= 1'b1;
			count_q     <= '0;
			marker_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SCALE:    scale_q    <= cfg_data;
					REG_X_OFFSET: xoff_q     <= cfg_data;
					REG_Y_OFFSET: yoff_q     <= cfg_data;
					REG_START_X:  anchor_x_q <= cfg_data;
					REG_START_Y:  anchor_y_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				marker_q <= 1'b0;
				if (req_data.opcode == OP_YAW)
					heading_q <= req_data.heading_rad;
			end
			unique case (state_q)
				ST_X_FIN: begin
					cur_x_q    <= pos_x_new;
					anchor_x_q <= pos_x_new;
				end
				ST_Y_FIN: begin
					cur_y_q    <= pos_y_new;
					anchor_y_q <= pos_y_new;
					if (count_inc == CNT_W'(POINT_INTERVAL)) begin
						marker_q <= 1'b1;
						count_q  <= '0;
					end else begin
						count_q <= count_inc;
					end
				end
				ST_G_N:  cur_x_q <= gps_x_new;
				ST_G_FIN: begin
					cur_y_q <= gps_y_new;
					if (first_fix_q) begin
						anchor_x_q  <= cur_x_q;
						anchor_y_q  <= gps_y_new;
						first_fix_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_load)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.pos_x        <= cur_x_q;
			res_q.pos_y        <= cur_y_q;
			res_q.point_marker <= marker_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_cordic_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_X_LO |-> cor_res.done)
		else $error("cordic result used before it finished");
	a_marker_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(marker_q) |-> count_q == '0)
		else $error("point marker set without count restart");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted request left the sequencer idle");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(res_valid_q && res_stall))
		else $error("result overwritten while still waiting");

endmodule

`default_nettype wire

// ===== rtl/core/drp_cordic.sv =====
// ----------------------------------------------------------------------------
// drp_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, giving the
// cosine and sine of a Q3.13 heading as Q4.30 values.
// ----------------------------------------------------------------------------
`default_nettype none

module drp_cordic #(
	parameter int STEPS = drp_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [drp_pkg::HEAD_W-1:0]   heading,
	output drp_pkg::cor_res_t                        res
);
	import drp_pkg::*;

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic signed [COR_ZW-1:0] HALF_PI_Z = COR_ZW'(HALF_PI_Q16);
	localparam logic signed [COR_ZW-1:0] PI_Z      = COR_ZW'(PI_Q16);

	logic signed [COR_XW-1:0] x_q, y_q;
	logic signed [COR_ZW-1:0] z_q;
	logic [IW-1:0]            idx_q;
	logic                     busy_q, done_q, flip_q;

	logic signed [COR_ZW-1:0] z_in, z_red;
	logic                     flip_in;
	logic signed [COR_XW-1:0] x_sh, y_sh;
	logic signed [COR_ZW-1:0] ang;

	always_comb begin
		z_in    = COR_ZW'(signed'({heading, 3'b000}));
		z_red   = z_in;
		flip_in = 1'b0;
		if (z_in > HALF_PI_Z) begin
			z_red   = z_in - PI_Z;
			flip_in = 1'b1;
		end else if (z_in < -HALF_PI_Z) begin
			z_red   = z_in + PI_Z;
			flip_in = 1'b1;
		end
		x_sh = x_q >>> idx_q;
		y_sh = y_q >>> idx_q;
		ang  = COR_ZW'({1'b0, atan_q16(5'(idx_q))});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (idx_q == IW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= COR_XW'(CORDIC_GAIN_Q30);
			y_q    <= '0;
			z_q    <= z_red;
			flip_q <= flip_in;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + ang;
			end
		end
	end

	assign res.done  = done_q;
	assign res.cos_v = flip_q ? -x_q : x_q;
	assign res.sin_v = flip_q ? -y_q : y_q;

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && !done_q && idx_q == '0)
		else $error("cordic did not restart");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= IW'(STEPS - 1))
		else $error("cordic step index past last step");

endmodule

`default_nettype wire
